// ----- src/dbcs_pkg.sv -----
// Shared types and constants for the text glyph locator.
`default_nettype none
package dbcs_pkg;

  // Request actions on the input channel
  typedef enum logic [1:0] {
    ACT_START     = 2'd0,
    ACT_TEXT      = 2'd1,
    ACT_WIDE_WR   = 2'd2,
    ACT_NARROW_WR = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIDE_W      = 3'd0;
  localparam logic [2:0] CFG_WIDE_H      = 3'd1;
  localparam logic [2:0] CFG_WIDE_CNT    = 3'd2;
  localparam logic [2:0] CFG_NARROW_W    = 3'd3;
  localparam logic [2:0] CFG_NARROW_H    = 3'd4;
  localparam logic [2:0] CFG_NARROW_CNT  = 3'd5;
  localparam logic [2:0] CFG_NARROW_FRST = 3'd6;
  localparam logic [2:0] CFG_FLAGS       = 3'd7;

  // Bit positions in the font flags register
  localparam int FLAG_WIDE    = 0;
  localparam int FLAG_NARROW  = 1;
  localparam int FLAG_TABLE   = 2;
  localparam int FLAG_REVERSE = 3;

  // Code drawn when a character is missing ('?')
  localparam logic [6:0] FALLBACK_CODE = 7'h3F;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WSRCH,
    S_NFIND,
    S_NSRCH,
    S_MUL,
    S_OUT
  } state_t;

  // Status returned by a code ring after a search pass
  typedef struct packed {
    logic       done;
    logic       found;
    logic [7:0] index;
  } srch_stat_t;

endpackage
`default_nettype wire

// ----- src/dbcs_cell.sv -----
// One code table entry in a rotating ring of cells.
`default_nettype none
module dbcs_cell #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             load_en,
  input  wire logic [WIDTH-1:0] load_data,
  input  wire logic             shift_en,
  input  wire logic [WIDTH-1:0] shift_in,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  // Load a table write, else take the neighbor's entry while rotating
  always_comb begin
    q_nxt = q_r;
    if (load_en) begin
      q_nxt = load_data;
    end else if (shift_en) begin
      q_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- src/dbcs_ring.sv -----
// Code table as a ring of cells, searched at the head during one full rotation.
`default_nettype none
module dbcs_ring #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [7:0]           wr_index,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 start,
  input  wire logic [WIDTH-1:0]     code,
  input  wire logic [8:0]           count,
  output dbcs_pkg::srch_stat_t      stat
);
  import dbcs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (IW > 8) ? IW : 8;
  localparam int CW = (IW > 9) ? IW : 9;

  logic [WIDTH-1:0] q [DEPTH];

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic [WIDTH-1:0] code_r, code_nxt;
  logic [8:0]       count_r, count_nxt;
  logic             found_r, found_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic             match_now;

  // Row of cells; each takes its upper neighbor's entry while busy
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dbcs_cell #(.WIDTH(WIDTH)) u_cell (
      .clk       (clk),
      .load_en   (wr_en && (XW'(wr_index) == XW'(i))),
      .load_data (wr_data),
      .shift_en  (busy_r),
      .shift_in  (q[(i + 1) % DEPTH]),
      .q         (q[i])
    );
  end

  // Head cell holds entry k_r; only the first k < count is a valid hit
  assign match_now = busy_r && (q[0] == code_r) && (CW'(k_r) < CW'(count_r));

  // Step the rotation and record the first hit
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    k_nxt     = k_r;
    code_nxt  = code_r;
    count_nxt = count_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    if (start) begin
      busy_nxt  = 1'b1;
      k_nxt     = '0;
      code_nxt  = code;
      count_nxt = count;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      if (match_now && !found_r) begin
        found_nxt = 1'b1;
        idx_nxt   = 8'(k_r);
      end
      if (k_r == IW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r     <= k_nxt;
    code_r  <= code_nxt;
    count_r <= count_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
  end

  assign stat.done  = done_r;
  assign stat.found = found_r;
  assign stat.index = idx_r;

endmodule
`default_nettype wire

// ----- src/dbcs_text_glyph_locator_top.sv -----
// Top level of the double-byte text glyph locator.
// Takes start, text byte and table write requests and returns one glyph draw
// command per drawn character. Start and table write requests are handled in
// the idle state. A text byte found without a table search passes through the
// find, multiply and output states. A table search rotates the whole code ring
// once; a missing character adds a narrow lookup of '?', so the worst case is
// set by the rotation of the two code rings. One request is processed at a
// time; a finished command waits in the output register while the next
// request is taken.
`default_nettype none
module dbcs_text_glyph_locator_top #(
  parameter int WIDE_ENTRIES   = 256,
  parameter int NARROW_ENTRIES = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [8:0]         cfg_data,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic [7:0]         in_text_byte,
  input  wire logic [7:0]         in_table_index,
  input  wire logic [15:0]        in_table_code,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_draw_x,
  output logic signed [15:0]      out_draw_y,
  output logic [5:0]              out_glyph_width,
  output logic [5:0]              out_glyph_height,
  output logic                    out_from_wide_font,
  output logic [7:0]              out_glyph_index,
  output logic [15:0]             out_glyph_byte_offset,
  output logic                    out_draw_reversed
);
  import dbcs_pkg::*;

  // Configuration registers
  logic [5:0] wide_w_r, wide_h_r, nar_w_r, nar_h_r;
  logic [8:0] wide_cnt_r;
  logic [7:0] nar_cnt_r;
  logic [6:0] nar_first_r;
  logic [3:0] flags_r;

  // String and controller state
  state_t      state_r, state_nxt;
  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] line_y_r, line_y_nxt;
  logic        lead_pend_r, lead_pend_nxt;
  logic [7:0]  lead_byte_r, lead_byte_nxt;
  logic        ended_r, ended_nxt;
  logic [6:0]  nfcode_r, nfcode_nxt;
  logic        fb_r, fb_nxt;
  logic        wide_sel_r, wide_sel_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [11:0] prod_r, prod_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_x_r, out_y_r, out_off_r;
  logic [5:0]  out_w_r, out_h_r;
  logic        out_wide_r, out_rev_r;
  logic [7:0]  out_idx_r;

  logic        in_acc;
  logic        load_out;
  logic        wstart, nstart, wr_wide, wr_nar;
  logic        hit, miss;
  logic [7:0]  hit_idx;
  logic [5:0]  sel_w, sel_h;
  logic [3:0]  sel_cols;
  logic [6:0]  w_plus;
  logic [17:0] off_full;
  logic [6:0]  contig_diff;
  logic        contig_hit;
  srch_stat_t  wstat, nstat;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Glyph size of the selected font and bytes per bitmap row
  assign sel_w    = wide_sel_r ? wide_w_r : nar_w_r;
  assign sel_h    = wide_sel_r ? wide_h_r : nar_h_r;
  assign w_plus   = {1'b0, sel_w} + 7'd7;
  assign sel_cols = w_plus[6:3];
  assign off_full = {6'b0, prod_r} * {12'b0, sel_h};

  // Contiguous narrow range lookup
  assign contig_diff = nfcode_r - nar_first_r;
  assign contig_hit  = (nfcode_r >= nar_first_r) && ({1'b0, contig_diff} < nar_cnt_r);

  // Code rings
  dbcs_ring #(.DEPTH(WIDE_ENTRIES), .WIDTH(16)) u_wide_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_wide),
    .wr_index (in_table_index),
    .wr_data  (in_table_code),
    .start    (wstart),
    .code     ({lead_byte_r, in_text_byte}),
    .count    (wide_cnt_r),
    .stat     (wstat)
  );

  dbcs_ring #(.DEPTH(NARROW_ENTRIES), .WIDTH(7)) u_narrow_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_nar),
    .wr_index (in_table_index),
    .wr_data  (in_table_code[6:0]),
    .start    (nstart),
    .code     (nfcode_r),
    .count    ({1'b0, nar_cnt_r}),
    .stat     (nstat)
  );

  // Next state and controls
  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    line_y_nxt    = line_y_r;
    lead_pend_nxt = lead_pend_r;
    lead_byte_nxt = lead_byte_r;
    ended_nxt     = ended_r;
    nfcode_nxt    = nfcode_r;
    fb_nxt        = fb_r;
    wide_sel_nxt  = wide_sel_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    wstart        = 1'b0;
    nstart        = 1'b0;
    wr_wide       = 1'b0;
    wr_nar        = 1'b0;
    hit           = 1'b0;
    miss          = 1'b0;
    hit_idx       = 8'd0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_START: begin
              cursor_x_nxt  = in_start_x;
              line_y_nxt    = in_start_y;
              lead_pend_nxt = 1'b0;
              ended_nxt     = 1'b0;
            end
            ACT_WIDE_WR:   wr_wide = 1'b1;
            ACT_NARROW_WR: wr_nar  = 1'b1;
            ACT_TEXT: begin
              if (!ended_r) begin
                if (in_text_byte == 8'd0) begin
                  ended_nxt     = 1'b1;
                  lead_pend_nxt = 1'b0;
                end else if (!in_text_byte[7]) begin
                  lead_pend_nxt = 1'b0;
                  if (flags_r[FLAG_NARROW]) begin
                    nfcode_nxt = in_text_byte[6:0];
                    fb_nxt     = 1'b0;
                    state_nxt  = S_NFIND;
                  end
                end else if (lead_pend_r) begin
                  lead_pend_nxt = 1'b0;
                  if (flags_r[FLAG_WIDE]) begin
                    if (wide_cnt_r != 9'd0) begin
                      wstart    = 1'b1;
                      state_nxt = S_WSRCH;
                    end else if (flags_r[FLAG_NARROW]) begin
                      nfcode_nxt = FALLBACK_CODE;
                      fb_nxt     = 1'b1;
                      state_nxt  = S_NFIND;
                    end
                  end
                end else begin
                  lead_pend_nxt = 1'b1;
                  lead_byte_nxt = in_text_byte;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WSRCH: begin
        if (wstat.done) begin
          if (wstat.found) begin
            wide_sel_nxt = 1'b1;
            idx_nxt      = wstat.index;
            state_nxt    = S_MUL;
          end else if (flags_r[FLAG_NARROW]) begin
            nfcode_nxt = FALLBACK_CODE;
            fb_nxt     = 1'b1;
            state_nxt  = S_NFIND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NFIND: begin
        if (nar_cnt_r == 8'd0) begin
          miss = 1'b1;
        end else if (!flags_r[FLAG_TABLE]) begin
          hit     = contig_hit;
          miss    = !contig_hit;
          hit_idx = {1'b0, contig_diff};
        end else begin
          nstart    = 1'b1;
          state_nxt = S_NSRCH;
        end
      end
      S_NSRCH: begin
        if (nstat.done) begin
          hit     = nstat.found;
          miss    = !nstat.found;
          hit_idx = nstat.index;
        end
      end
      S_MUL: begin
        prod_nxt  = {4'b0, idx_r} * {8'b0, sel_cols};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out     = 1'b1;
          cursor_x_nxt = cursor_x_r + {10'b0, sel_w};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Narrow lookup outcome: draw, retry with '?', or advance without a glyph
    if (hit) begin
      wide_sel_nxt = 1'b0;
      idx_nxt      = hit_idx;
      state_nxt    = S_MUL;
    end else if (miss) begin
      if (fb_r) begin
        cursor_x_nxt = cursor_x_r + {10'b0, nar_w_r};
        state_nxt    = S_IDLE;
      end else begin
        nfcode_nxt = FALLBACK_CODE;
        fb_nxt     = 1'b1;
        state_nxt  = S_NFIND;
      end
    end
  end

  // Hold the result until taken, then drop valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_w_r    <= 6'd12;
      wide_h_r    <= 6'd12;
      wide_cnt_r  <= 9'd0;
      nar_w_r     <= 6'd6;
      nar_h_r     <= 6'd12;
      nar_cnt_r   <= 8'd96;
      nar_first_r <= 7'd32;
      flags_r     <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDE_W:      wide_w_r    <= cfg_data[5:0];
        CFG_WIDE_H:      wide_h_r    <= cfg_data[5:0];
        CFG_WIDE_CNT:    wide_cnt_r  <= cfg_data;
        CFG_NARROW_W:    nar_w_r     <= cfg_data[5:0];
        CFG_NARROW_H:    nar_h_r     <= cfg_data[5:0];
        CFG_NARROW_CNT:  nar_cnt_r   <= cfg_data[7:0];
        CFG_NARROW_FRST: nar_first_r <= cfg_data[6:0];
        CFG_FLAGS:       flags_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Control and string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_x_r  <= 16'd0;
      line_y_r    <= 16'd0;
      lead_pend_r <= 1'b0;
      lead_byte_r <= 8'd0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      line_y_r    <= line_y_nxt;
      lead_pend_r <= lead_pend_nxt;
      lead_byte_r <= lead_byte_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
    nfcode_r   <= nfcode_nxt;
    fb_r       <= fb_nxt;
    wide_sel_r <= wide_sel_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= cursor_x_r;
      out_y_r    <= line_y_r;
      out_w_r    <= sel_w;
      out_h_r    <= sel_h;
      out_wide_r <= wide_sel_r;
      out_idx_r  <= idx_r;
      out_off_r  <= off_full[15:0];
      out_rev_r  <= flags_r[FLAG_REVERSE];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_draw_x            = out_x_r;
  assign out_draw_y            = out_y_r;
  assign out_glyph_width       = out_w_r;
  assign out_glyph_height      = out_h_r;
  assign out_from_wide_font    = out_wide_r;
  assign out_glyph_index       = out_idx_r;
  assign out_glyph_byte_offset = out_off_r;
  assign out_draw_reversed     = out_rev_r;

endmodule
`default_nettype wire

// ----- src/dbcs_checker.sv -----
// Port-level checks for the text glyph locator, bound to the top level.
`default_nettype none
module dbcs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [1:0]         in_action,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_draw_x,
  input wire logic [7:0]         out_glyph_index
);
  import dbcs_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_draw_x) && $stable(out_glyph_index))
    else $error("result payload changed while stalled");

  // Start and table write requests leave the input unstalled in the cycle after they are taken
  a_quick_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action != ACT_TEXT) |=> !in_stall)
    else $error("non-text request held the input");

  // A new result only appears after the block was busy with a request
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind dbcs_text_glyph_locator_top dbcs_checker u_dbcs_checker (.*);
`default_nettype wire

// ----- verif/dbcs_glyph_checker.sv -----
`timescale 1ns / 1ps
// Checker for the glyph locator: shadows its state, predicts draw commands and compares them.
module dbcs_glyph_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic [7:0]         in_text_byte,
  input  logic [7:0]         in_table_index,
  input  logic [15:0]        in_table_code,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_draw_x,
  input  logic signed [15:0] out_draw_y,
  input  logic [5:0]         out_glyph_width,
  input  logic [5:0]         out_glyph_height,
  input  logic               out_from_wide_font,
  input  logic [7:0]         out_glyph_index,
  input  logic [15:0]        out_glyph_byte_offset,
  input  logic               out_draw_reversed,
  output int                 fail_count,
  output int                 pending
);
  import dbcs_pkg::*;

  localparam int WIDE_DEPTH   = 256;
  localparam int NARROW_DEPTH = 128;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [5:0]  w;
    logic [5:0]  h;
    logic        wide;
    logic [7:0]  idx;
    logic [15:0] off;
    logic        rev;
  } glyph_cmd_t;

  // Shadow font registers
  logic [5:0] wide_w, wide_h, narrow_w, narrow_h;
  logic [8:0] wide_cnt;
  logic [7:0] narrow_cnt;
  logic [6:0] narrow_first;
  logic [3:0] flags;

  // Shadow string state and code tables
  logic [15:0] cur_x, line_y;
  logic        lead_held, text_done;
  logic [7:0]  lead_val;
  logic [15:0] wide_codes [WIDE_DEPTH];
  logic [6:0]  narrow_codes [NARROW_DEPTH];

  glyph_cmd_t  glyph_q [$];
  int          mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Return the narrow glyph index of a code, or -1 when it is missing
  function automatic int narrow_lookup(int code);
    int n;
    int rel;
    if (!flags[FLAG_NARROW] || narrow_cnt == 0) return -1;
    if (!flags[FLAG_TABLE]) begin
      rel = code - int'(narrow_first);
      if (rel < 0 || rel >= int'(narrow_cnt)) return -1;
      return rel;
    end
    n = (narrow_cnt < NARROW_DEPTH) ? int'(narrow_cnt) : NARROW_DEPTH;
    for (int i = 0; i < n; i++) begin
      if (narrow_codes[i] === code[6:0]) return i;
    end
    return -1;
  endfunction

  // Return the wide glyph index of a double-byte code, or -1 when it is missing
  function automatic int wide_lookup(logic [15:0] code);
    int n;
    if (!flags[FLAG_WIDE] || wide_cnt == 0) return -1;
    n = (wide_cnt < WIDE_DEPTH) ? int'(wide_cnt) : WIDE_DEPTH;
    for (int i = 0; i < n; i++) begin
      if (wide_codes[i] === code) return i;
    end
    return -1;
  endfunction

  // Advance the string state by one text byte and queue the glyph it draws
  task automatic take_text(logic [7:0] b);
    int         idx;
    logic       use_wide;
    logic [5:0] w, h;
    glyph_cmd_t cmd;
    if (text_done) return;
    if (b == 8'd0) begin
      text_done = 1'b1;
      lead_held = 1'b0;
      return;
    end
    if (b < 8'd128) begin
      lead_held = 1'b0;
      idx = narrow_lookup(int'(b));
      use_wide = 1'b0;
      if (!flags[FLAG_NARROW]) return;
    end else if (lead_held) begin
      lead_held = 1'b0;
      idx = wide_lookup({lead_val, b});
      use_wide = 1'b1;
      if (!flags[FLAG_WIDE]) return;
    end else begin
      lead_held = 1'b1;
      lead_val = b;
      return;
    end
    // Fall back to the narrow '?' for a missing character
    if (idx < 0) begin
      use_wide = 1'b0;
      if (!flags[FLAG_NARROW]) return;
      idx = narrow_lookup(int'(FALLBACK_CODE));
    end
    w = use_wide ? wide_w : narrow_w;
    h = use_wide ? wide_h : narrow_h;
    if (idx >= 0) begin
      cmd.x    = cur_x;
      cmd.y    = line_y;
      cmd.w    = w;
      cmd.h    = h;
      cmd.wide = use_wide;
      cmd.idx  = idx[7:0];
      cmd.off  = 16'(idx * ((int'(w) + 7) / 8) * int'(h));
      cmd.rev  = flags[FLAG_REVERSE];
      glyph_q.push_back(cmd);
    end
    cur_x = cur_x + 16'(w);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    glyph_cmd_t want;
    if (!rst_n) begin
      wide_w       = 6'd12;
      wide_h       = 6'd12;
      wide_cnt     = 9'd0;
      narrow_w     = 6'd6;
      narrow_h     = 6'd12;
      narrow_cnt   = 8'd96;
      narrow_first = 7'd32;
      flags        = 4'd0;
      cur_x        = '0;
      line_y       = '0;
      lead_held    = 1'b0;
      lead_val     = '0;
      text_done    = 1'b0;
      for (int i = 0; i < WIDE_DEPTH; i++) wide_codes[i] = '0;
      for (int i = 0; i < NARROW_DEPTH; i++) narrow_codes[i] = '0;
      glyph_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDE_W:      wide_w = cfg_data[5:0];
          CFG_WIDE_H:      wide_h = cfg_data[5:0];
          CFG_WIDE_CNT:    wide_cnt = cfg_data;
          CFG_NARROW_W:    narrow_w = cfg_data[5:0];
          CFG_NARROW_H:    narrow_h = cfg_data[5:0];
          CFG_NARROW_CNT:  narrow_cnt = cfg_data[7:0];
          CFG_NARROW_FRST: narrow_first = cfg_data[6:0];
          CFG_FLAGS:       flags = cfg_data[3:0];
          default: ;
        endcase
      end
      // Compare each accepted draw command with the oldest prediction
      if (out_valid && !out_stall) begin
        if (glyph_q.size() == 0) begin
          $error("draw command with none expected");
          mismatches++;
        end else begin
          want = glyph_q.pop_front();
          check_field("draw_x", want.x, out_draw_x);
          check_field("draw_y", want.y, out_draw_y);
          check_field("glyph_width", 16'(want.w), 16'(out_glyph_width));
          check_field("glyph_height", 16'(want.h), 16'(out_glyph_height));
          check_field("from_wide_font", 16'(want.wide), 16'(out_from_wide_font));
          check_field("glyph_index", 16'(want.idx), 16'(out_glyph_index));
          check_field("glyph_byte_offset", want.off, out_glyph_byte_offset);
          check_field("draw_reversed", 16'(want.rev), 16'(out_draw_reversed));
        end
      end
      // Predict from each accepted request
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_START: begin
            cur_x     = in_start_x;
            line_y    = in_start_y;
            lead_held = 1'b0;
            text_done = 1'b0;
          end
          ACT_WIDE_WR:
            if (int'(in_table_index) < WIDE_DEPTH) wide_codes[in_table_index] = in_table_code;
          ACT_NARROW_WR:
            if (int'(in_table_index) < NARROW_DEPTH)
              narrow_codes[in_table_index] = in_table_code[6:0];
          ACT_TEXT: take_text(in_text_byte);
          default: ;
        endcase
      end
    end
    pending    <= glyph_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- verif/tb_dbcs_text_glyph_locator_top.sv -----
`timescale 1ns / 1ps
// Testbench top: drives requests and font setups into the glyph locator and reports the verdict.
module tb_dbcs_text_glyph_locator_top;
  import dbcs_pkg::*;

  localparam int ITEMS_PER_PHASE = 160;
  localparam int NUM_PHASES      = 10;
  localparam int SETTLE_CYCLES   = 420;
  localparam int SQUEEZE_CYCLES  = 2000;
  localparam int WATCHDOG_LIMIT  = 12000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_WIDE_W;
  logic [8:0]  cfg_data  = '0;

  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action      = ACT_START;
  logic signed [15:0] in_start_x     = '0;
  logic signed [15:0] in_start_y     = '0;
  logic [7:0]         in_text_byte   = '0;
  logic [7:0]         in_table_index = '0;
  logic [15:0]        in_table_code  = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_draw_x, out_draw_y;
  logic [5:0]         out_glyph_width, out_glyph_height;
  logic               out_from_wide_font;
  logic [7:0]         out_glyph_index;
  logic [15:0]        out_glyph_byte_offset;
  logic               out_draw_reversed;

  int fail_count;
  int pending;

  // Stimulus-side view of the tables and fonts, used only to pick likely characters
  logic [15:0] sh_wide [256];
  logic [6:0]  sh_narrow [128];
  int          sh_wcnt, sh_ncnt, sh_first;
  logic [3:0]  sh_flags;
  bit          in_string       = 1'b1;
  int          items_done      = 0;
  int          sender_idle_pct = 0;
  int          sink_idle_pct   = 25;
  bit          squeeze_go      = 1'b0;
  bit          squeeze_done    = 1'b0;
  int          stuck_cycles    = 0;

  always #5 clk = ~clk;

  dbcs_text_glyph_locator_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_start_x            (in_start_x),
    .in_start_y            (in_start_y),
    .in_text_byte          (in_text_byte),
    .in_table_index        (in_table_index),
    .in_table_code         (in_table_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_draw_x            (out_draw_x),
    .out_draw_y            (out_draw_y),
    .out_glyph_width       (out_glyph_width),
    .out_glyph_height      (out_glyph_height),
    .out_from_wide_font    (out_from_wide_font),
    .out_glyph_index       (out_glyph_index),
    .out_glyph_byte_offset (out_glyph_byte_offset),
    .out_draw_reversed     (out_draw_reversed)
  );

  dbcs_glyph_checker glyph_chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_start_x            (in_start_x),
    .in_start_y            (in_start_y),
    .in_text_byte          (in_text_byte),
    .in_table_index        (in_table_index),
    .in_table_code         (in_table_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_draw_x            (out_draw_x),
    .out_draw_y            (out_draw_y),
    .out_glyph_width       (out_glyph_width),
    .out_glyph_height      (out_glyph_height),
    .out_from_wide_font    (out_from_wide_font),
    .out_glyph_index       (out_glyph_index),
    .out_glyph_byte_offset (out_glyph_byte_offset),
    .out_draw_reversed     (out_draw_reversed),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // Offer one request and hold it until accepted; unused fields carry noise
  task automatic send_req(action_t act, logic [15:0] arg_a, logic [15:0] arg_b);
    logic [15:0] sx, sy, tc;
    logic [7:0]  tb, ti;
    sx = 16'($urandom);
    sy = 16'($urandom);
    tb = 8'($urandom);
    ti = 8'($urandom);
    tc = 16'($urandom);
    case (act)
      ACT_START: begin
        sx = arg_a;
        sy = arg_b;
      end
      ACT_TEXT: tb = arg_a[7:0];
      default: begin
        ti = arg_a[7:0];
        tc = arg_b;
      end
    endcase
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    in_action      <= act;
    in_start_x     <= sx;
    in_start_y     <= sy;
    in_text_byte   <= tb;
    in_table_index <= ti;
    in_table_code  <= tc;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    // Ignored text after the end of a string does not count
    if (act != ACT_TEXT || in_string) items_done++;
    case (act)
      ACT_START:     in_string = 1'b1;
      ACT_WIDE_WR:   sh_wide[ti] = tc;
      ACT_NARROW_WR: if (ti < 8'd128) sh_narrow[ti[6:0]] = tc[6:0];
      default:       if (tb == 8'd0) in_string = 1'b0;
    endcase
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic program_fonts(int ww, int wh, int wc, int nw, int nh, int nc, int nf, int fl);
    write_reg(CFG_WIDE_W, 9'(ww));
    write_reg(CFG_WIDE_H, 9'(wh));
    write_reg(CFG_WIDE_CNT, 9'(wc));
    write_reg(CFG_NARROW_W, 9'(nw));
    write_reg(CFG_NARROW_H, 9'(nh));
    write_reg(CFG_NARROW_CNT, 9'(nc));
    write_reg(CFG_NARROW_FRST, 9'(nf));
    write_reg(CFG_FLAGS, 9'(fl));
    cfg_we   <= 1'b0;
    sh_wcnt  = wc & 9'h1FF;
    sh_ncnt  = nc & 8'hFF;
    sh_first = nf & 7'h7F;
    sh_flags = fl[3:0];
  endtask

  // Drain all predicted commands, then let a request that draws nothing finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Send one character, mostly ones the current fonts can find
  task automatic send_char();
    int          pick, n, c;
    logic [15:0] code;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if (sh_flags[FLAG_TABLE]) begin
        n = (sh_ncnt < 128) ? sh_ncnt : 128;
        c = (n > 0) ? int'(sh_narrow[$urandom_range(n - 1)]) : 0;
      end else begin
        c = sh_first + ((sh_ncnt > 0) ? int'($urandom_range(sh_ncnt - 1)) : 0);
      end
      if (c < 1 || c > 127) c = $urandom_range(1, 127);
      send_req(ACT_TEXT, 16'(c), 16'($urandom));
    end else if (pick < 75) begin
      n = (sh_wcnt < 256) ? sh_wcnt : 256;
      if (n > 0 && $urandom_range(9) > 1) code = sh_wide[$urandom_range(n - 1)];
      else code = {1'b1, 7'($urandom), 1'b1, 7'($urandom)};
      send_req(ACT_TEXT, {8'd0, code[15:8]}, 16'($urandom));
      send_req(ACT_TEXT, {8'd0, code[7:0]}, 16'($urandom));
    end else if (pick < 92) begin
      send_req(ACT_TEXT, 16'($urandom_range(1, 255)), 16'($urandom));
    end else if (pick < 96) begin
      send_req(ACT_TEXT, 16'd0, 16'($urandom));
    end else if (pick < 98) begin
      send_req(ACT_WIDE_WR, 16'($urandom), {1'b1, 7'($urandom), 1'b1, 7'($urandom)});
    end else begin
      send_req(ACT_NARROW_WR, 16'($urandom_range(0, 255)), 16'($urandom));
    end
  endtask

  // Strings of random content, mostly well formed
  task automatic run_random(int n);
    int target;
    target = items_done + n;
    while (items_done < target) begin
      if ((!in_string && $urandom_range(3) != 0) || $urandom_range(99) < 3)
        send_req(ACT_START, 16'($urandom), 16'($urandom));
      else
        send_char();
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (squeeze_go && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
        squeeze_done = 1'b1;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        out_stall <= 1'b1;
        repeat (idle_len() - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stop a run that makes no progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load both code tables so no search reads an unwritten entry
    for (int i = 0; i < 256; i++)
      send_req(ACT_WIDE_WR, 16'(i), ($urandom_range(9) != 0) ?
               {1'b1, 7'($urandom), 1'b1, 7'($urandom)} : 16'($urandom));
    for (int i = 0; i < 128; i++)
      send_req(ACT_NARROW_WR, 16'(i), (i == 5) ? 16'(FALLBACK_CODE) : 16'($urandom));
    settle();

    // Directed: contiguous narrow font, wide font, reverse drawing
    sender_idle_pct = 30;
    program_fonts(12, 12, 256, 6, 12, 96, 32, 4'b1011);
    send_req(ACT_START, 16'h7FFF, 16'h8000);
    send_req(ACT_TEXT, 16'h20, 16'h0);       // first code of the range
    send_req(ACT_TEXT, 16'h7F, 16'h0);       // last code of the range
    send_req(ACT_TEXT, 16'h1F, 16'h0);       // below the range: falls back to '?'
    send_req(ACT_WIDE_WR, 16'hFF, 16'hFFFF);
    send_req(ACT_TEXT, 16'hFF, 16'h0);
    send_req(ACT_TEXT, 16'hFF, 16'h0);
    send_req(ACT_WIDE_WR, 16'h00, 16'h8080);
    send_req(ACT_TEXT, 16'h80, 16'h0);
    send_req(ACT_TEXT, 16'h80, 16'h0);
    send_req(ACT_TEXT, 16'h81, 16'h0);       // lead byte dropped by a narrow byte
    send_req(ACT_TEXT, 16'h41, 16'h0);
    send_req(ACT_TEXT, 16'h82, 16'h0);
    send_req(ACT_TEXT, 16'h83, 16'h0);
    send_req(ACT_NARROW_WR, 16'hC8, 16'hFFFF); // index beyond the narrow table
    send_req(ACT_NARROW_WR, 16'h7F, 16'hFFC1);
    send_req(ACT_TEXT, 16'h90, 16'h0);       // pending lead dropped by end of string
    send_req(ACT_TEXT, 16'h00, 16'h0);
    send_req(ACT_TEXT, 16'h41, 16'h0);       // ignored after end of string
    send_req(ACT_TEXT, 16'h90, 16'h0);
    send_req(ACT_START, 16'h8000, 16'h7FFF);
    send_req(ACT_TEXT, 16'h90, 16'h0);
    send_req(ACT_TEXT, 16'h3F, 16'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: program_fonts(1, 1, 1, 1, 1, 1, 0, 4'b0111);
          2: program_fonts(32, 32, 256, 32, 32, 128, 127, 4'b1111);
          3: program_fonts(0, 63, 511, 63, 0, 255, 100, 4'b0011);
          4: program_fonts(12, 12, 0, 6, 12, 0, 32, 4'b1111);
          5: program_fonts(8, 16, 200, 8, 16, 96, 32, 4'b0000);
          6: program_fonts(16, 16, 256, 8, 8, 64, 16, 4'b0001);
          7: program_fonts(24, 24, 256, 6, 12, 64, 0, 4'b0110);
          default: program_fonts($urandom_range(1, 32), $urandom_range(1, 32),
                                 $urandom_range(0, 256), $urandom_range(1, 32),
                                 $urandom_range(1, 32), $urandom_range(0, 128),
                                 $urandom_range(0, 127), $urandom_range(0, 15));
        endcase
      end
      sender_idle_pct = (p % 3 == 2) ? 0 : 30;
      sink_idle_pct   = (p % 4 == 3) ? 0 : 25;
      if (p == 0) squeeze_go = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- dbcs_text_glyph_locator_top.f -----
src/dbcs_pkg.sv
src/dbcs_cell.sv
src/dbcs_ring.sv
src/dbcs_text_glyph_locator_top.sv
src/dbcs_checker.sv
verif/dbcs_glyph_checker.sv
verif/tb_dbcs_text_glyph_locator_top.sv
